>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion helpers
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// invariant that holds on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant violated");

// implication checked on every clock edge out of reset
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication violated");

// consequence checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check violated");

`endif

>>> hw/rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants of the positional list engine
// element store sizing, operation and status codes, request and result structs
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int ELEM_W   = 8;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [1:0] {
    MODE_GET    = 2'd0,
    MODE_FIND   = 2'd1,
    MODE_INSERT = 2'd2,
    MODE_DELETE = 2'd3
  } ple_mode_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BADPOS   = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } ple_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PUT,
    S_DONE
  } ple_state_t;

  typedef struct packed {
    ple_mode_t          mode;
    logic [POS_W-1:0]   position;
    logic [ELEM_W-1:0]  value;
  } ple_req_t;

  typedef struct packed {
    ple_status_t        status;
    logic [ELEM_W-1:0]  element;
    logic [POS_W-1:0]   found_position;
    logic [POS_W-1:0]   list_length;
  } ple_rsp_t;

  typedef struct packed {
    logic idle;
    logic done;
  } ple_ctl_t;

endpackage

>>> hw/rtl/positional_list_engine.sv
// get, find and delete walk store cells, insert shifts cells up and then writes the new one
// an append at the end or a rejected request skips the walk; a receiver stall holds results back
// one item at a time: a new request is taken once the last result is in the output register
// the single store read port walks one cell per cycle
// a finished result waits in the output register while the next item is taken
// reset (synchronous, rst_n low): list empty, no result pending, store left as is
// ----------------------------------------------------------------------------
// positional_list_engine: ordered byte list addressed by 1-based position
// get, find, insert and delete over a fixed-capacity element store
// ----------------------------------------------------------------------------
module positional_list_engine import ple_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [POS_W-1:0]   in_position,
  input  logic [ELEM_W-1:0]  in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [ELEM_W-1:0]  out_element,
  output logic [POS_W-1:0]   out_found_position,
  output logic [POS_W-1:0]   out_list_length
);

  ple_req_t  req;
  ple_rsp_t  rsp;
  ple_ctl_t  ctl;
  logic      slot_free;
  logic      out_valid_r, out_valid_nxt;
  ple_rsp_t  out_r, out_nxt;

  assign req.mode     = ple_mode_t'(in_mode);
  assign req.position = in_position;
  assign req.value    = in_value;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = ctl.idle;

  ple_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_valid && ctl.idle),
    .req   (req),
    .ack   (slot_free),
    .ctl   (ctl),
    .rsp   (rsp)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.done && slot_free) begin
      out_valid_nxt = 1'b1;
      out_nxt       = rsp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_element        = out_r.element;
  assign out_found_position = out_r.found_position;
  assign out_list_length    = out_r.list_length;

endmodule

>>> hw/rtl/ple_ram.sv
// ----------------------------------------------------------------------------
// ple_ram: generic single-write, single-read memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module ple_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/ple_core.sv
// ----------------------------------------------------------------------------
// ple_core: list sequencer
// walks the element store one cell per cycle to get, find, shift up or down
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ple_core import ple_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  ple_req_t  req,
  input  logic      ack,
  output ple_ctl_t  ctl,
  output ple_rsp_t  rsp
);

  ple_state_t         state_r, state_nxt;
  ple_mode_t          mode_r, mode_nxt;
  logic [ADDR_W-1:0]  pos_r, pos_nxt;
  logic [ELEM_W-1:0]  val_r, val_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  logic [ADDR_W-1:0]  end_r, end_nxt;
  logic               more_r, more_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [ADDR_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic               first_r, first_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  ple_status_t        status_r, status_nxt;
  logic [ELEM_W-1:0]  elem_r, elem_nxt;
  logic [POS_W-1:0]   found_r, found_nxt;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [ELEM_W-1:0]  wdata;
  logic [ADDR_W-1:0]  raddr;
  logic [ELEM_W-1:0]  rdata;

  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   cnt_ext;

  ple_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      more_r   <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      more_r   <= more_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    idx_r    <= idx_nxt;
    end_r    <= end_nxt;
    rd_idx_r <= rd_idx_nxt;
    first_r  <= first_nxt;
    status_r <= status_nxt;
    elem_r   <= elem_nxt;
    found_r  <= found_nxt;
  end

  assign pos_ext = CMP_W'(req.position);
  assign cnt_ext = CMP_W'(count_r);

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    idx_nxt    = idx_r;
    end_nxt    = end_r;
    more_nxt   = more_r;
    rd_vld_nxt = 1'b0;
    rd_idx_nxt = rd_idx_r;
    first_nxt  = first_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    elem_nxt   = elem_r;
    found_nxt  = found_r;
    we         = 1'b0;
    waddr      = rd_idx_r;
    wdata      = rdata;
    raddr      = idx_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt   = req.mode;
          val_nxt    = req.value;
          pos_nxt    = ADDR_W'(pos_ext - CMP_W'(1));
          status_nxt = STAT_OK;
          elem_nxt   = '0;
          found_nxt  = '0;
          first_nxt  = 1'b1;
          more_nxt   = 1'b0;
          state_nxt  = S_DONE;
          case (req.mode)
            MODE_GET, MODE_DELETE: begin
              if (pos_ext == '0 || pos_ext > cnt_ext) begin
                status_nxt = STAT_BADPOS;
              end else begin
                idx_nxt   = ADDR_W'(pos_ext - CMP_W'(1));
                end_nxt   = (req.mode == MODE_GET) ? ADDR_W'(pos_ext - CMP_W'(1)) :
                                                     ADDR_W'(cnt_ext - CMP_W'(1));
                more_nxt  = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            MODE_FIND: begin
              if (count_r == '0) begin
                status_nxt = STAT_NOTFOUND;
              end else begin
                idx_nxt   = '0;
                end_nxt   = ADDR_W'(cnt_ext - CMP_W'(1));
                more_nxt  = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            MODE_INSERT: begin
              if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
                status_nxt = STAT_BADPOS;
              end else if (count_r == CNT_W'(CAPACITY)) begin
                status_nxt = STAT_FULL;
              end else if (pos_ext == cnt_ext + CMP_W'(1)) begin
                state_nxt = S_PUT;
              end else begin
                idx_nxt   = ADDR_W'(cnt_ext - CMP_W'(1));
                end_nxt   = ADDR_W'(pos_ext - CMP_W'(1));
                more_nxt  = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue one read per cycle
        if (more_r) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = idx_r;
          if (idx_r == end_r) begin
            more_nxt = 1'b0;
          end else if (mode_r == MODE_INSERT) begin
            idx_nxt = idx_r - ADDR_W'(1);
          end else begin
            idx_nxt = idx_r + ADDR_W'(1);
          end
        end
        // consume the data read last cycle
        if (rd_vld_r) begin
          case (mode_r)
            MODE_GET: begin
              elem_nxt = rdata;
            end
            MODE_DELETE: begin
              if (first_r) begin
                elem_nxt  = rdata;
                first_nxt = 1'b0;
              end else begin
                we    = 1'b1;
                waddr = rd_idx_r - ADDR_W'(1);
              end
            end
            MODE_INSERT: begin
              we    = 1'b1;
              waddr = rd_idx_r + ADDR_W'(1);
            end
            MODE_FIND: begin
              if (rdata == val_r) begin
                found_nxt  = POS_W'(CNT_W'(rd_idx_r) + CNT_W'(1));
                more_nxt   = 1'b0;
                rd_vld_nxt = 1'b0;
                state_nxt  = S_DONE;
              end
            end
            default: begin
              we = 1'b0;
            end
          endcase
          // last element consumed
          if (!more_r && state_nxt == S_SCAN) begin
            case (mode_r)
              MODE_INSERT: begin
                state_nxt = S_PUT;
              end
              MODE_DELETE: begin
                count_nxt = count_r - CNT_W'(1);
                state_nxt = S_DONE;
              end
              MODE_FIND: begin
                status_nxt = STAT_NOTFOUND;
                state_nxt  = S_DONE;
              end
              default: begin
                state_nxt = S_DONE;
              end
            endcase
          end
        end
      end

      S_PUT: begin
        we        = 1'b1;
        waddr     = pos_r;
        wdata     = val_r;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (ack) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ctl.idle = (state_r == S_IDLE);
  assign ctl.done = (state_r == S_DONE);

  assign rsp.status         = status_r;
  assign rsp.element        = elem_r;
  assign rsp.found_position = found_r;
  assign rsp.list_length    = POS_W'(count_r);

  `ASSERT_ALWAYS(a_count_cap, count_r <= CNT_W'(CAPACITY))
  `ASSERT_IMPLIES(a_no_idle_write, state_r == S_IDLE || state_r == S_DONE, !we)
  `ASSERT_IMPLIES(a_write_in_range, we, CNT_W'(waddr) <= count_r)
  `ASSERT_IMPLIES(a_done_drained, state_r == S_DONE, !more_r && !rd_vld_r)
  `ASSERT_NEXT(a_put_grows, state_r == S_PUT, count_r == $past(count_r) + CNT_W'(1))

endmodule

>>> dv/tb_positional_list_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine: self-checking bench for the positional list engine
// a queue-fed driver offers get, find, insert and delete requests in bursts, a
// shadow list predicts every result, and a monitor checks each result transfer in order
// ----------------------------------------------------------------------------
module tb_positional_list_engine;
  import ple_pkg::*;

  localparam int RAND_ITEMS  = 427;
  localparam int PAUSE_AT    = 300;
  localparam int HOLD_AT     = 120;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 2 * CAPACITY + 20;
  localparam int LIMIT       = 400000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_mode = '0;
  logic [POS_W-1:0]  in_position = '0;
  logic [ELEM_W-1:0] in_value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_status;
  logic [ELEM_W-1:0] out_element;
  logic [POS_W-1:0]  out_found_position;
  logic [POS_W-1:0]  out_list_length;

  positional_list_engine dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_element        (out_element),
    .out_found_position (out_found_position),
    .out_list_length    (out_list_length)
  );

  ple_req_t          req_q [$];
  ple_rsp_t          due_rsp_q [$];
  logic [ELEM_W-1:0] shadow_cells [CAPACITY];
  int unsigned       shadow_len = 0;
  int                plan_len = 0;
  int                items_sent = 0;
  int                miss_cnt = 0;
  int                cycle_cnt = 0;
  logic              in_xfer = 1'b0;
  int                burst_left = 0;
  int                gap_left = 0;
  int                hold_left = 0;
  logic              hold_done = 1'b0;
  int                rcv_cyc = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow list: applies one request and returns the result it should give
  function automatic ple_rsp_t list_apply(ple_req_t req);
    ple_rsp_t    rsp;
    int unsigned pos;
    rsp = '0;
    rsp.status = STAT_OK;
    pos = 32'(req.position);
    case (req.mode)
      MODE_GET: begin
        if (pos == 0 || pos > shadow_len) rsp.status = STAT_BADPOS;
        else rsp.element = shadow_cells[pos-1];
      end
      MODE_FIND: begin
        rsp.status = STAT_NOTFOUND;
        for (int unsigned j = 0; j < shadow_len; j++) begin
          if (rsp.status == STAT_NOTFOUND && shadow_cells[j] == req.value) begin
            rsp.status = STAT_OK;
            rsp.found_position = POS_W'(j + 1);
          end
        end
      end
      MODE_INSERT: begin
        if (pos == 0 || pos > shadow_len + 1) rsp.status = STAT_BADPOS;
        else if (shadow_len >= CAPACITY) rsp.status = STAT_FULL;
        else begin
          for (int unsigned j = shadow_len; j > pos - 1; j--) begin
            shadow_cells[j] = shadow_cells[j-1];
          end
          shadow_cells[pos-1] = req.value;
          shadow_len++;
        end
      end
      default: begin
        if (pos == 0 || pos > shadow_len) rsp.status = STAT_BADPOS;
        else begin
          rsp.element = shadow_cells[pos-1];
          for (int unsigned j = pos - 1; j + 1 < shadow_len; j++) begin
            shadow_cells[j] = shadow_cells[j+1];
          end
          shadow_len--;
        end
      end
    endcase
    rsp.list_length = shadow_len[POS_W-1:0];
    return rsp;
  endfunction

  // queues a request and keeps track of the list length it leaves behind
  function automatic void queue_item(ple_mode_t mode, int pos, int val);
    ple_req_t req;
    req.mode = mode;
    req.position = pos[POS_W-1:0];
    req.value = val[ELEM_W-1:0];
    req_q.push_back(req);
    if (mode == MODE_INSERT && pos >= 1 && pos <= plan_len + 1 && plan_len < CAPACITY)
      plan_len++;
    else if (mode == MODE_DELETE && pos >= 1 && pos <= plan_len)
      plan_len--;
  endfunction

  function automatic int access_pos();
    int s;
    s = $urandom_range(0, 99);
    if (s < 80) return (plan_len == 0) ? 1 : $urandom_range(1, plan_len);
    else if (s < 90) return (s % 2) ? 0 : plan_len + 1;
    else return $urandom_range(0, 127);
  endfunction

  function automatic int insert_pos();
    int s;
    s = $urandom_range(0, 99);
    if (s < 30) return plan_len + 1;
    else if (s < 85) return $urandom_range(1, plan_len + 1);
    else return $urandom_range(0, 127);
  endfunction

  function automatic int pick_value();
    return $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 255);
  endfunction

  task automatic report_miss(input string why, input ple_rsp_t want,
                             input ple_rsp_t got);
    miss_cnt++;
    if (miss_cnt <= 10)
      $display("%0t result error (%s): expected st=%0d el=%0d fp=%0d len=%0d, %s",
               $time, why, want.status, want.element, want.found_position,
               want.list_length,
               $sformatf("got st=%0d el=%0d fp=%0d len=%0d",
                         got.status, got.element, got.found_position, got.list_length));
  endtask

  // monitor: checks result transfers, then logs request transfers
  always @(posedge clk) begin
    ple_rsp_t got;
    ple_rsp_t want;
    if (rst_n) begin
      in_xfer = in_valid && in_ready;
      if (out_valid && out_ready) begin
        got.status = ple_status_t'(out_status);
        got.element = out_element;
        got.found_position = out_found_position;
        got.list_length = out_list_length;
        if (due_rsp_q.size() == 0) begin
          report_miss("unexpected", '0, got);
        end else begin
          want = due_rsp_q.pop_front();
          if (got !== want) report_miss("wrong field", want, got);
        end
      end
      if (in_xfer) begin
        due_rsp_q.push_back(list_apply('{ple_mode_t'(in_mode), in_position, in_value}));
        items_sent++;
      end
    end else begin
      in_xfer = 1'b0;
    end
  end

  // driver: bursts of requests with random gaps, one pause to let pending results drain
  always @(negedge clk) begin
    ple_req_t nxt;
    logic     give;
    if (rst_n && !(in_valid && !in_xfer)) begin
      give = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (req_q.size() != 0 &&
                   !(items_sent == PAUSE_AT && due_rsp_q.size() != 0)) begin
        give = 1'b1;
        nxt = req_q.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap_left = 0;
            9:          gap_left = $urandom_range(20, 40);
            default:    gap_left = $urandom_range(1, 8);
          endcase
        end else begin
          burst_left--;
        end
      end
      in_valid <= give;
      if (give) begin
        in_mode <= nxt.mode;
        in_position <= nxt.position;
        in_value <= nxt.value;
      end
    end
  end

  // receiver: rotating stall pattern plus one long hold-off
  always @(negedge clk) begin
    logic rdy;
    if (rst_n) begin
      rcv_cyc++;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        rdy = 1'b0;
      end else begin
        case ((rcv_cyc / 200) % 4)
          0:       rdy = 1'b1;
          1:       rdy = $urandom_range(0, 9) < 7;
          2:       rdy = (rcv_cyc % 6) < 4;
          default: rdy = $urandom_range(0, 9) < 3;
        endcase
      end
      out_ready <= rdy;
    end
  end

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int r;
    int w_ins;
    int w_del;
    int w_get;
    int total;

    // empty list corners
    queue_item(MODE_GET, 1, 8'h3c);
    queue_item(MODE_GET, 0, 8'hff);
    queue_item(MODE_DELETE, 1, 8'h00);
    queue_item(MODE_FIND, 5, 8'h00);
    queue_item(MODE_INSERT, 0, 8'h11);
    queue_item(MODE_INSERT, 2, 8'h22);
    // build ff 5a 00 a5 through front, middle and end inserts
    queue_item(MODE_INSERT, 1, 8'h00);
    queue_item(MODE_INSERT, 1, 8'hff);
    queue_item(MODE_INSERT, 3, 8'ha5);
    queue_item(MODE_INSERT, 2, 8'h5a);
    queue_item(MODE_INSERT, 127, 8'h01);
    queue_item(MODE_GET, 1, 8'h00);
    queue_item(MODE_GET, 4, 8'hff);
    queue_item(MODE_GET, 5, 8'h00);
    queue_item(MODE_GET, 127, 8'h00);
    queue_item(MODE_FIND, 127, 8'ha5);
    queue_item(MODE_FIND, 0, 8'h00);
    queue_item(MODE_FIND, 64, 8'h33);
    queue_item(MODE_DELETE, 4, 8'hff);
    queue_item(MODE_DELETE, 1, 8'h00);
    queue_item(MODE_DELETE, 64, 8'h00);
    queue_item(MODE_DELETE, 0, 8'h00);
    queue_item(MODE_GET, 64, 8'h00);

    // fill toward full, mix, drain toward empty, mix
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i < 200) begin
        w_ins = 60; w_del = 70; w_get = 85;
      end else if (i >= 250 && i < 400) begin
        w_ins = 10; w_del = 65; w_get = 82;
      end else begin
        w_ins = 30; w_del = 55; w_get = 78;
      end
      r = $urandom_range(0, 99);
      if (r < w_ins) queue_item(MODE_INSERT, insert_pos(), pick_value());
      else if (r < w_del) queue_item(MODE_DELETE, access_pos(), $urandom_range(0, 255));
      else if (r < w_get) queue_item(MODE_GET, access_pos(), $urandom_range(0, 255));
      else queue_item(MODE_FIND, $urandom_range(0, 127), pick_value());
    end
    total = req_q.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (items_sent < total) @(posedge clk);
    while (due_rsp_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (miss_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
